[hw/rtl/lpagc_pkg.sv]
// lpagc_pkg: shared types and constants of the look-ahead peak agc
// used by the datapath, the sequencer and the top level, depends on nothing
`default_nettype none

package lpagc_pkg;

  // default look-ahead depth of the delay ring
  localparam int unsigned WINDOW_DEPTH_DEF = 4096;

  // fixed field widths
  localparam int unsigned SMP_W    = 16;
  localparam int unsigned GAIN_W   = 32;
  localparam int unsigned STEP_W   = 31;
  localparam int unsigned WLEN_W   = 13;
  localparam int unsigned HANG_W   = 17;
  localparam int unsigned CFG_A_W  = 3;
  localparam int unsigned CFG_D_W  = 32;
  localparam int unsigned MUL_W    = 33;
  localparam int unsigned PROD_W   = 2 * MUL_W;

  // gain constants, Q16.16
  localparam logic [GAIN_W-1:0] GAIN_UNITY = 32'd65536;
  localparam logic [GAIN_W-1:0] GAIN_FLOOR = 32'd6554;

  // configuration register indexes
  localparam logic [CFG_A_W-1:0] CFG_AGC_EN   = 3'd0;
  localparam logic [CFG_A_W-1:0] CFG_MANUAL   = 3'd1;
  localparam logic [CFG_A_W-1:0] CFG_TARGET   = 3'd2;
  localparam logic [CFG_A_W-1:0] CFG_MAX_GAIN = 3'd3;
  localparam logic [CFG_A_W-1:0] CFG_ATTACK   = 3'd4;
  localparam logic [CFG_A_W-1:0] CFG_DECAY    = 3'd5;
  localparam logic [CFG_A_W-1:0] CFG_WINDOW   = 3'd6;
  localparam logic [CFG_A_W-1:0] CFG_HANG     = 3'd7;

  // input and output words
  typedef struct packed {
    logic signed [SMP_W-1:0] in_i;
    logic signed [SMP_W-1:0] in_q;
  } in_word_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] out_i;
    logic signed [SMP_W-1:0] out_q;
    logic [GAIN_W-1:0]       gain_now;
  } out_word_t;

  // operand selection of the shared multiplier
  typedef enum logic [2:0] {
    MUL_NONE  = 3'd0,
    MUL_FLOOR = 3'd1,
    MUL_GAIN  = 3'd2,
    MUL_SMP_I = 3'd3,
    MUL_SMP_Q = 3'd4
  } mul_op_e;

  // controller to datapath
  typedef struct packed {
    logic    in_load;
    logic    cfg_we;
    logic    leaf_wr;
    logic    tree_rd;
    logic    tree_wr;
    mul_op_e mul_op;
    logic    div_peak;
    logic    div_mod;
    logic    mod_wr;
    logic    tgt_upd;
    logic    gain_upd;
    logic    res_i_ld;
    logic    out_load;
  } lpagc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_busy;
    logic agc_en;
    logic tree_eq;
    logic tree_top;
    logic above;
    logic div_busy;
    logic out_free;
  } lpagc_stat_t;

endpackage

`default_nettype wire

[hw/rtl/lpagc_div.sv]
// lpagc_div: restoring divider, one quotient bit per cycle
// depends on no package; house widths (32-bit operands)
`default_nettype none

module lpagc_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] dividend_i,
  input  wire logic [31:0] divisor_i,
  output logic             busy_o,
  output logic [31:0]      quot_o,
  output logic [31:0]      rem_o
);

  logic [31:0] quot_q, quot_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] dvs_q, dvs_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [32:0] trial;
  logic [32:0] diff;

  // one shift-subtract step
  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q, quot_q[31]};
    diff   = trial - {1'b0, dvs_q};
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = 6'd32;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[32]) begin
        rem_d  = diff[31:0];
        quot_d = {quot_q[30:0], 1'b1};
      end else begin
        rem_d  = trial[31:0];
        quot_d = {quot_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // operands and partial results
  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

[hw/rtl/lpagc_dp.sv]
// lpagc_dp: datapath of the look-ahead peak agc: registers, delay ring, max tree,
// shared multiplier, divider and output register; depends on lpagc_pkg, lpagc_div
`default_nettype none

module lpagc_dp #(
  parameter int unsigned WINDOW_DEPTH = lpagc_pkg::WINDOW_DEPTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire lpagc_pkg::lpagc_cmd_t         cmd_i,
  output lpagc_pkg::lpagc_stat_t             stat_o,
  input  wire lpagc_pkg::in_word_t           in_word_i,
  input  wire logic [lpagc_pkg::CFG_A_W-1:0] cfg_addr_i,
  input  wire logic [lpagc_pkg::CFG_D_W-1:0] cfg_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output lpagc_pkg::out_word_t               out_word_o
);

  localparam int unsigned LEAF_W = (WINDOW_DEPTH > 2) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned LEAVES = 1 << LEAF_W;
  localparam int unsigned TA_W   = LEAF_W + 1;
  localparam int unsigned LEN_W  = LEAF_W + 1;
  localparam logic [TA_W-1:0] ROOT_A = TA_W'(2 * LEAVES - 2);
  localparam logic [TA_W-1:0] LAST_A = TA_W'(2 * LEAVES - 1);

  localparam int unsigned SW = lpagc_pkg::SMP_W;
  localparam int unsigned GW = lpagc_pkg::GAIN_W;
  localparam int unsigned HW = lpagc_pkg::HANG_W;
  localparam int unsigned PW = lpagc_pkg::PROD_W;
  localparam int unsigned MW = lpagc_pkg::MUL_W;

  // saturate a product to Q1.15 after dropping 16 fraction bits
  function automatic logic [SW-1:0] sat_smp(input logic signed [PW-1:0] p);
    logic signed [PW-17:0] s;
    logic [SW-1:0] r;
    s = p[PW-1:16];
    if (s > (PW-16)'(signed'(32767))) begin
      r = 16'h7fff;
    end else if (s < -(PW-16)'(signed'(32768))) begin
      r = 16'h8000;
    end else begin
      r = s[SW-1:0];
    end
    return r;
  endfunction

  // configuration registers
  logic                            agc_q;
  logic [GW-1:0]                   manual_q;
  logic [SW-1:0]                   target_q;
  logic [GW-1:0]                   max_gain_q;
  logic [lpagc_pkg::STEP_W-1:0]    attack_q;
  logic [lpagc_pkg::STEP_W-1:0]    decay_q;
  logic [lpagc_pkg::WLEN_W-1:0]    window_q;
  logic [SW-1:0]                   hang_smp_q;

  // processing state
  logic [GW-1:0]     gain_q;
  logic [GW-1:0]     tgt_q;
  logic [HW-1:0]     hang_q;
  logic [LEAF_W-1:0] wp_q;
  lpagc_pkg::in_word_t smp_q;
  logic [LEAF_W-1:0] p_q;
  logic              att_q, dec_q;
  logic [SW-1:0]     peak_q;

  // tree walk registers
  logic [SW-1:0]     walk_q;
  logic [LEAF_W-1:0] idx_q;
  logic [TA_W-1:0]   ofs_q;
  logic [TA_W-1:0]   base_q;
  logic [SW-1:0]     sib_q, par_q;

  // memories
  logic [31:0]   dline [LEAVES];
  logic [SW-1:0] tree  [2*LEAVES];
  logic [31:0]   dl_rd_q;

  // clearing pass
  logic            clr_busy_q;
  logic [TA_W-1:0] clr_q;

  // multiplier and output
  logic signed [PW-1:0] prod_q;
  logic signed [MW-1:0] ma, mb;
  logic [SW-1:0]        res_i_q;
  logic                 out_valid_q;
  lpagc_pkg::out_word_t out_q;

  // divider
  logic        div_start, div_busy;
  logic [31:0] div_n, div_dv, quot, rem;

  // combinational helpers
  logic [31:0]       wl32;
  logic [LEN_W-1:0]  eff_len;
  logic [LEAF_W-1:0] p_now;
  logic [LEN_W-1:0]  nxt;
  logic [LEAF_W-1:0] wp_nxt;
  logic [SW-1:0]     mag_i, mag_q, mag;
  logic [SW:0]       neg_i, neg_q;
  logic [TA_W-1:0]   sib_a, par_a;
  logic [SW-1:0]     m_val;
  logic              above;
  logic [GW-1:0]     tgt_n;
  logic [HW-1:0]     hang_n;
  logic [GW-1:0]     scaled, g1, g2;
  logic              cfg_gain;
  logic              new_agc;
  logic [GW-1:0]     new_man;
  logic [PW-1:0]     prod_u;

  // effective window length
  always_comb begin
    wl32 = 32'(window_q);
    if (wl32 == 32'd0) begin
      eff_len = LEN_W'(1);
    end else if (wl32 > 32'(WINDOW_DEPTH)) begin
      eff_len = LEN_W'(WINDOW_DEPTH);
    end else begin
      eff_len = LEN_W'(wl32);
    end
  end

  // ring position of this sample and the next
  always_comb begin
    p_now = (LEN_W'(wp_q) >= eff_len) ? '0 : wp_q;
    nxt   = LEN_W'(p_q) + LEN_W'(1);
    wp_nxt = (nxt >= eff_len) ? '0 : nxt[LEAF_W-1:0];
  end

  // peak magnitude of the new pair
  always_comb begin
    neg_i = -{smp_q.in_i[SW-1], smp_q.in_i};
    neg_q = -{smp_q.in_q[SW-1], smp_q.in_q};
    mag_i = smp_q.in_i[SW-1] ? neg_i[SW-1:0] : smp_q.in_i;
    mag_q = smp_q.in_q[SW-1] ? neg_q[SW-1:0] : smp_q.in_q;
    mag   = (mag_i > mag_q) ? mag_i : mag_q;
  end

  // tree walk addresses and compare
  assign sib_a = ofs_q + TA_W'(idx_q ^ LEAF_W'(1));
  assign par_a = ofs_q + base_q + TA_W'(idx_q >> 1);
  assign m_val = (walk_q > sib_q) ? walk_q : sib_q;

  // floor test on the peak product
  assign prod_u = prod_q;
  assign above  = prod_u > PW'({target_q, 16'b0});

  // new target and hang count
  always_comb begin
    tgt_n  = tgt_q;
    hang_n = hang_q;
    if (above) begin
      if (quot < tgt_q) begin
        if (gain_q > tgt_q) begin
          hang_n = HW'(eff_len) + HW'(hang_smp_q);
        end
        tgt_n = quot;
      end else if (hang_q == '0) begin
        tgt_n = quot;
      end
    end else begin
      tgt_n  = max_gain_q;
      hang_n = '0;
    end
  end

  // gain step, clamp and floor
  always_comb begin
    scaled = (prod_u[PW-1:62] != '0) ? '1 : prod_u[61:30];
    g1 = (att_q || dec_q) ? scaled : gain_q;
    if (!att_q && (hang_q == '0) && (g1 > tgt_q)) begin
      g1 = tgt_q;
    end
    g2 = (g1 < lpagc_pkg::GAIN_FLOOR) ? lpagc_pkg::GAIN_FLOOR : g1;
  end

  // gain reload on a manual-mode write
  always_comb begin
    new_agc  = (cfg_addr_i == lpagc_pkg::CFG_AGC_EN) ? cfg_data_i[0] : agc_q;
    new_man  = (cfg_addr_i == lpagc_pkg::CFG_MANUAL) ? cfg_data_i : manual_q;
    cfg_gain = cmd_i.cfg_we && !new_agc &&
               ((cfg_addr_i == lpagc_pkg::CFG_AGC_EN) ||
                (cfg_addr_i == lpagc_pkg::CFG_MANUAL));
  end

  // multiplier operands
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd_i.mul_op)
      lpagc_pkg::MUL_FLOOR: begin
        ma = MW'(peak_q);
        mb = MW'(max_gain_q);
      end
      lpagc_pkg::MUL_GAIN: begin
        ma = MW'(gain_q);
        mb = MW'(att_q ? attack_q : decay_q);
      end
      lpagc_pkg::MUL_SMP_I: begin
        ma = agc_q ? MW'($signed(dl_rd_q[15:0])) : MW'(smp_q.in_i);
        mb = MW'(gain_q);
      end
      lpagc_pkg::MUL_SMP_Q: begin
        ma = agc_q ? MW'($signed(dl_rd_q[31:16])) : MW'(smp_q.in_q);
        mb = MW'(gain_q);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_op != lpagc_pkg::MUL_NONE) begin
      prod_q <= ma * mb;
    end
  end

  // divider operands
  assign div_start = cmd_i.div_peak || cmd_i.div_mod;
  assign div_n     = cmd_i.div_peak ? {target_q, 16'b0} : 32'(wp_q);
  assign div_dv    = cmd_i.div_peak ? 32'(peak_q) : 32'(eff_len);

  lpagc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_n),
    .divisor_i  (div_dv),
    .busy_o     (div_busy),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      agc_q      <= 1'b0;
      manual_q   <= lpagc_pkg::GAIN_UNITY;
      target_q   <= 16'd32768;
      max_gain_q <= 32'd65536000;
      attack_q   <= 31'd1073741824;
      decay_q    <= 31'd1073741824;
      window_q   <= 13'd128;
      hang_smp_q <= '0;
    end else if (cmd_i.cfg_we) begin
      unique case (cfg_addr_i)
        lpagc_pkg::CFG_AGC_EN:   agc_q      <= cfg_data_i[0];
        lpagc_pkg::CFG_MANUAL:   manual_q   <= cfg_data_i;
        lpagc_pkg::CFG_TARGET:   target_q   <= cfg_data_i[SW-1:0];
        lpagc_pkg::CFG_MAX_GAIN: max_gain_q <= cfg_data_i;
        lpagc_pkg::CFG_ATTACK:   attack_q   <= cfg_data_i[lpagc_pkg::STEP_W-1:0];
        lpagc_pkg::CFG_DECAY:    decay_q    <= cfg_data_i[lpagc_pkg::STEP_W-1:0];
        lpagc_pkg::CFG_WINDOW:   window_q   <= cfg_data_i[lpagc_pkg::WLEN_W-1:0];
        lpagc_pkg::CFG_HANG:     hang_smp_q <= cfg_data_i[SW-1:0];
        default: ;
      endcase
    end
  end

  // gain, target, hang and write pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= lpagc_pkg::GAIN_UNITY;
      tgt_q  <= '0;
      hang_q <= '0;
      wp_q   <= '0;
      att_q  <= 1'b0;
      dec_q  <= 1'b0;
      peak_q <= '0;
    end else begin
      if (cfg_gain) begin
        gain_q <= new_man;
      end else if (cmd_i.gain_upd) begin
        gain_q <= g2;
      end
      if (cmd_i.tgt_upd) begin
        tgt_q <= tgt_n;
        hang_q <= hang_n;
        att_q <= gain_q > tgt_n;
        dec_q <= (gain_q <= tgt_n) && (hang_n == '0) && (gain_q < tgt_n);
      end else if (cmd_i.gain_upd && (hang_q != '0)) begin
        hang_q <= hang_q - HW'(1);
      end
      if (cmd_i.mod_wr) begin
        wp_q <= rem[LEAF_W-1:0];
      end else if (cmd_i.gain_upd) begin
        wp_q <= wp_nxt;
      end
      if (cmd_i.tree_wr && (par_a == ROOT_A)) begin
        peak_q <= m_val;
      end
    end
  end

  // input word and tree walk registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      smp_q <= in_word_i;
    end
    if (cmd_i.leaf_wr) begin
      p_q    <= p_now;
      walk_q <= mag;
      idx_q  <= p_now;
      ofs_q  <= '0;
      base_q <= TA_W'(LEAVES);
    end else if (cmd_i.tree_wr) begin
      walk_q <= m_val;
      idx_q  <= idx_q >> 1;
      ofs_q  <= ofs_q + base_q;
      base_q <= base_q >> 1;
    end
  end

  // clearing pass after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_q      <= '0;
    end else if (clr_busy_q) begin
      clr_q <= clr_q + TA_W'(1);
      if (clr_q == LAST_A) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // delay ring, read old word before it is overwritten
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      dline[clr_q[LEAF_W-1:0]] <= '0;
    end else if (cmd_i.leaf_wr) begin
      dline[p_now] <= {smp_q.in_q, smp_q.in_i};
    end
    if (cmd_i.leaf_wr) begin
      dl_rd_q <= dline[p_now];
    end
  end

  // max tree, one write and two reads
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      tree[clr_q] <= '0;
    end else if (cmd_i.leaf_wr) begin
      tree[TA_W'(p_now)] <= mag;
    end else if (cmd_i.tree_wr) begin
      tree[par_a] <= m_val;
    end
    if (cmd_i.tree_rd) begin
      sib_q <= tree[sib_a];
      par_q <= tree[par_a];
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_i_ld) begin
      res_i_q <= sat_smp(prod_q);
    end
    if (cmd_i.out_load) begin
      out_q.out_i    <= res_i_q;
      out_q.out_q    <= sat_smp(prod_q);
      out_q.gain_now <= gain_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // status to the controller
  assign stat_o.clr_busy = clr_busy_q;
  assign stat_o.agc_en   = agc_q;
  assign stat_o.tree_eq  = (par_q == m_val);
  assign stat_o.tree_top = (base_q == TA_W'(2));
  assign stat_o.above    = above;
  assign stat_o.div_busy = div_busy;
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

endmodule

`default_nettype wire

[hw/rtl/lpagc_ctrl.sv]
// lpagc_ctrl: sequencer of the look-ahead peak agc, drives datapath commands
// depends on lpagc_pkg
`default_nettype none

module lpagc_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [lpagc_pkg::CFG_A_W-1:0] cfg_addr_i,
  input  wire lpagc_pkg::lpagc_stat_t        stat_i,
  output lpagc_pkg::lpagc_cmd_t              cmd_o
);

  typedef enum logic [14:0] {
    ST_IDLE = 15'h0001,
    ST_LEAF = 15'h0002,
    ST_TRD  = 15'h0004,
    ST_TCMP = 15'h0008,
    ST_FMUL = 15'h0010,
    ST_FCMP = 15'h0020,
    ST_DIVW = 15'h0040,
    ST_TGT  = 15'h0080,
    ST_GMUL = 15'h0100,
    ST_GSET = 15'h0200,
    ST_MI   = 15'h0400,
    ST_MQ   = 15'h0800,
    ST_OUTW = 15'h1000,
    ST_MODS = 15'h2000,
    ST_MODW = 15'h4000
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    cfg_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        cfg_ready_o = 1'b1;
        in_stall_o  = stat_i.clr_busy || cfg_valid_i;
        if (cfg_valid_i) begin
          cmd_o.cfg_we = 1'b1;
          if (cfg_addr_i == lpagc_pkg::CFG_WINDOW) begin
            state_d = ST_MODS;
          end
        end else if (in_valid_i && !stat_i.clr_busy) begin
          cmd_o.in_load = 1'b1;
          state_d = stat_i.agc_en ? ST_LEAF : ST_MI;
        end
      end
      ST_LEAF: begin
        cmd_o.leaf_wr = 1'b1;
        state_d = ST_TRD;
      end
      ST_TRD: begin
        cmd_o.tree_rd = 1'b1;
        state_d = ST_TCMP;
      end
      ST_TCMP: begin
        if (stat_i.tree_eq) begin
          state_d = ST_FMUL;
        end else begin
          cmd_o.tree_wr = 1'b1;
          state_d = stat_i.tree_top ? ST_FMUL : ST_TRD;
        end
      end
      ST_FMUL: begin
        cmd_o.mul_op = lpagc_pkg::MUL_FLOOR;
        state_d = ST_FCMP;
      end
      ST_FCMP: begin
        if (stat_i.above) begin
          cmd_o.div_peak = 1'b1;
          state_d = ST_DIVW;
        end else begin
          state_d = ST_TGT;
        end
      end
      ST_DIVW: begin
        if (!stat_i.div_busy) begin
          state_d = ST_TGT;
        end
      end
      ST_TGT: begin
        cmd_o.tgt_upd = 1'b1;
        state_d = ST_GMUL;
      end
      ST_GMUL: begin
        cmd_o.mul_op = lpagc_pkg::MUL_GAIN;
        state_d = ST_GSET;
      end
      ST_GSET: begin
        cmd_o.gain_upd = 1'b1;
        state_d = ST_MI;
      end
      ST_MI: begin
        cmd_o.mul_op = lpagc_pkg::MUL_SMP_I;
        state_d = ST_MQ;
      end
      ST_MQ: begin
        cmd_o.mul_op   = lpagc_pkg::MUL_SMP_Q;
        cmd_o.res_i_ld = 1'b1;
        state_d = ST_OUTW;
      end
      ST_OUTW: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_MODS: begin
        cmd_o.div_mod = 1'b1;
        state_d = ST_MODW;
      end
      ST_MODW: begin
        if (!stat_i.div_busy) begin
          cmd_o.mod_wr = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/lookahead_peak_agc_core.sv]
// lookahead_peak_agc_core: top level of the look-ahead peak agc
// depends on lpagc_pkg, lpagc_ctrl, lpagc_dp (which holds lpagc_div)
//
// Usage:
//   input channel : in_valid_i / in_stall_o, one I/Q word per accepted cycle
//   output channel: out_valid_o / out_stall_i, one word (samples and gain) per input
//   config channel: cfg_valid_i / cfg_ready_o with register index and data;
//                   write only while no word is in flight
// Timing, one word at a time:
//   manual mode: I and Q are scaled in turn by the manual gain, then the output register loads
//   agc mode: leaf write, max tree walk, floor test, a divide only when the window peak
//   is above the noise floor, target update, gain step, then I and Q scaling into the
//   output register; the 32-step divider and the walk of the max tree (up to log2 of
//   the leaf count levels, with early exit) make the time per word vary
//   a window_len write wraps the pointer through the divider; no word is taken meanwhile
// Reset: the configuration and control registers return to their defaults; then a
//   clearing pass over every tree address zeroes the ring and the tree,
//   during which input words are stalled and config writes are still taken
// Stall: a finished word waits in the output register; the next input word is
//   accepted and processed meanwhile, and its result holds until the register frees
`default_nettype none

module lookahead_peak_agc_core #(
  parameter int unsigned WINDOW_DEPTH = lpagc_pkg::WINDOW_DEPTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire lpagc_pkg::in_word_t           in_word_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output lpagc_pkg::out_word_t               out_word_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [lpagc_pkg::CFG_A_W-1:0] cfg_addr_i,
  input  wire logic [lpagc_pkg::CFG_D_W-1:0] cfg_data_i
);

  lpagc_pkg::lpagc_cmd_t  cmd;
  lpagc_pkg::lpagc_stat_t stat;

  // sequencer
  lpagc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_addr_i  (cfg_addr_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // datapath
  lpagc_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_word_i   (in_word_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire

[tb/testbench.sv]
// testbench: self-checking bench for lookahead_peak_agc_core, manual and agc modes
// depends on lpagc_pkg and the core; a scoreboard class predicts every output word
`default_nettype none

// gain predictor and store of expected output words
class agc_scoreboard;
  localparam int unsigned DEPTH  = 4096;
  localparam int unsigned LEAVES = 4096;

  lpagc_pkg::out_word_t expected_q[$];
  int unsigned fails;
  int unsigned checked;

  // register copies
  bit          agc_on;
  bit [31:0]   man_gain;
  bit [15:0]   tgt_mag;
  bit [31:0]   gain_cap;
  bit [30:0]   att_step;
  bit [30:0]   dec_step;
  bit [12:0]   win_len;
  bit [15:0]   hang_len;

  // block state copies
  bit [31:0]   ring[DEPTH];
  bit [15:0]   tree[2*LEAVES];
  int unsigned wr_ptr;
  bit [31:0]   cur_gain;
  bit [31:0]   tgt_gain;
  int unsigned hang_cnt;

  function new();
    agc_on   = 0;
    man_gain = 32'd65536;
    tgt_mag  = 16'd32768;
    gain_cap = 32'd65536000;
    att_step = 31'd1073741824;
    dec_step = 31'd1073741824;
    win_len  = 13'd128;
    hang_len = 0;
    foreach (ring[k]) ring[k] = 0;
    foreach (tree[k]) tree[k] = 0;
    wr_ptr   = 0;
    cur_gain = 32'd65536;
    tgt_gain = 0;
    hang_cnt = 0;
    fails    = 0;
    checked  = 0;
  endfunction

  function int unsigned span();
    int unsigned w;
    w = win_len;
    if (w == 0) w = 1;
    if (w > DEPTH) w = DEPTH;
    return w;
  endfunction

  // q16.16 gain times q1.30 step, saturated
  function bit [31:0] step_gain(bit [31:0] g, bit [30:0] s);
    longint unsigned p;
    p = (longint'(g) * longint'(s)) >> 30;
    return (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
  endfunction

  // sample times gain, floored and saturated
  function bit [15:0] scaled(bit [15:0] s, bit [31:0] g);
    longint p;
    p = longint'($signed(s)) * longint'(g);
    p = p >>> 16;
    if (p > 32767) p = 32767;
    if (p < -32768) p = -32768;
    return p[15:0];
  endfunction

  function void write_reg(logic [lpagc_pkg::CFG_A_W-1:0] idx, bit [31:0] val);
    case (idx)
      lpagc_pkg::CFG_AGC_EN:   agc_on = val[0];
      lpagc_pkg::CFG_MANUAL:   man_gain = val;
      lpagc_pkg::CFG_TARGET:   tgt_mag = val[15:0];
      lpagc_pkg::CFG_MAX_GAIN: gain_cap = val;
      lpagc_pkg::CFG_ATTACK:   att_step = val[30:0];
      lpagc_pkg::CFG_DECAY:    dec_step = val[30:0];
      lpagc_pkg::CFG_WINDOW: begin
        win_len = val[12:0];
        if (wr_ptr >= span()) wr_ptr = wr_ptr % span();
      end
      lpagc_pkg::CFG_HANG:     hang_len = val[15:0];
      default: ;
    endcase
    if ((idx == lpagc_pkg::CFG_AGC_EN || idx == lpagc_pkg::CFG_MANUAL) && !agc_on)
      cur_gain = man_gain;
  endfunction

  // max tree walk toward the root with early exit
  function void tree_walk(int unsigned p);
    int unsigned ofs, base;
    bit [15:0] a, b, m;
    ofs = 0;
    base = LEAVES;
    while (base > 1) begin
      a = tree[ofs + p];
      b = tree[ofs + (p ^ 1)];
      m = (a > b) ? a : b;
      p = p >> 1;
      ofs += base;
      if (tree[ofs + p] == m) break;
      tree[ofs + p] = m;
      base = base >> 1;
    end
  endfunction

  function void note_input(lpagc_pkg::in_word_t w);
    lpagc_pkg::out_word_t e;
    int unsigned len, p, ai, aq, pk;
    bit [31:0] old, nt;
    if (!agc_on) begin
      e.out_i = scaled(w.in_i, cur_gain);
      e.out_q = scaled(w.in_q, cur_gain);
      e.gain_now = cur_gain;
      expected_q.push_back(e);
      return;
    end
    len = span();
    if (wr_ptr >= len) wr_ptr = 0;
    p = wr_ptr;
    old = ring[p];
    ring[p] = {w.in_q, w.in_i};
    ai = (w.in_i < 0) ? -int'(w.in_i) : int'(w.in_i);
    aq = (w.in_q < 0) ? -int'(w.in_q) : int'(w.in_q);
    tree[p] = 16'((ai > aq) ? ai : aq);
    tree_walk(p);
    pk = tree[2*LEAVES - 2];
    // target gain from window peak, hang starts on a fresh attack
    if (longint'(pk) * longint'(gain_cap) > longint'(tgt_mag) * 65536) begin
      nt = 32'((longint'(tgt_mag) << 16) / pk);
      if (nt < tgt_gain) begin
        if (cur_gain > tgt_gain) hang_cnt = len + hang_len;
        tgt_gain = nt;
      end else if (hang_cnt == 0) begin
        tgt_gain = nt;
      end
    end else begin
      tgt_gain = gain_cap;
      hang_cnt = 0;
    end
    // attack, or decay clamped to target
    if (cur_gain > tgt_gain) begin
      cur_gain = step_gain(cur_gain, att_step);
    end else if (hang_cnt == 0) begin
      if (cur_gain < tgt_gain) cur_gain = step_gain(cur_gain, dec_step);
      if (cur_gain > tgt_gain) cur_gain = tgt_gain;
    end
    if (hang_cnt > 0) hang_cnt--;
    if (cur_gain < lpagc_pkg::GAIN_FLOOR) cur_gain = lpagc_pkg::GAIN_FLOOR;
    e.out_i = scaled(old[15:0], cur_gain);
    e.out_q = scaled(old[31:16], cur_gain);
    e.gain_now = cur_gain;
    expected_q.push_back(e);
    wr_ptr = (p + 1 >= len) ? 0 : p + 1;
  endfunction

  function void check(lpagc_pkg::out_word_t got);
    lpagc_pkg::out_word_t e;
    if (expected_q.size() == 0) begin
      $display("%0t: output word %h with nothing expected", $time, got);
      fails++;
      return;
    end
    e = expected_q.pop_front();
    checked++;
    if (got.out_i !== e.out_i) begin
      $display("%0t: out_i expected %h actual %h", $time, e.out_i, got.out_i);
      fails++;
    end
    if (got.out_q !== e.out_q) begin
      $display("%0t: out_q expected %h actual %h", $time, e.out_q, got.out_q);
      fails++;
    end
    if (got.gain_now !== e.gain_now) begin
      $display("%0t: gain_now expected %h actual %h", $time, e.gain_now, got.gain_now);
      fails++;
    end
  endfunction
endclass

module testbench;

  localparam longint unsigned CYCLE_LIMIT = 3000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  lpagc_pkg::in_word_t in_word_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  lpagc_pkg::out_word_t out_word_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [lpagc_pkg::CFG_A_W-1:0] cfg_addr_i = '0;
  logic [lpagc_pkg::CFG_D_W-1:0] cfg_data_i = '0;

  agc_scoreboard sb = new();
  longint unsigned cycles = 0;
  int unsigned hold_left = 0;
  bit hold_go = 0;
  int unsigned stall_mode = 0;
  int unsigned loud_level = 32767;

  lookahead_peak_agc_core DUT (.*);

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // output side: check accepted words, stall on its own pattern
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) sb.check(out_word_o);
    if (cycles % 256 == 0) stall_mode = $urandom_range(0, 3);
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else if (hold_go) begin
      hold_go = 0;
      hold_left = 4000;
      out_stall_i <= 1'b1;
    end else begin
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 3) == 0);
        2: out_stall_i <= ($urandom_range(0, 1) == 0);
        default: out_stall_i <= ($urandom_range(0, 9) < 8);
      endcase
    end
  end

  // one register write, then the channel goes idle
  task automatic cfg_write(logic [lpagc_pkg::CFG_A_W-1:0] idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk_i);
  endtask

  // offer one word, with an optional gap before it
  task automatic send_word(lpagc_pkg::in_word_t w, int unsigned gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(w);
  endtask

  // wait for every expected word plus the block's tail latency
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_sample();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 1) return 16'($urandom);
    if (r < 5) return 16'($urandom_range(0, 2 * loud_level) - loud_level);
    return 16'($urandom_range(0, 64) - 32);
  endfunction

  // random words in bursts; loudness changes between segments
  task automatic random_words(int unsigned n);
    lpagc_pkg::in_word_t w;
    int unsigned burst;
    burst = 0;
    for (int unsigned k = 0; k < n; k++) begin
      if (k % 40 == 0) loud_level = $urandom_range(1, 32767);
      w.in_i = pick_sample();
      w.in_q = pick_sample();
      if (burst == 0) begin
        burst = $urandom_range(1, 30);
        send_word(w, ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60));
      end else begin
        send_word(w, 0);
      end
      burst--;
    end
  endtask

  task automatic agc_setup(logic [31:0] tgt, logic [31:0] mx, logic [31:0] att,
                           logic [31:0] dec, logic [31:0] win, logic [31:0] hang);
    cfg_write(lpagc_pkg::CFG_TARGET, tgt);
    cfg_write(lpagc_pkg::CFG_MAX_GAIN, mx);
    cfg_write(lpagc_pkg::CFG_ATTACK, att);
    cfg_write(lpagc_pkg::CFG_DECAY, dec);
    cfg_write(lpagc_pkg::CFG_WINDOW, win);
    cfg_write(lpagc_pkg::CFG_HANG, hang);
    cfg_write(lpagc_pkg::CFG_AGC_EN, 32'd1);
  endtask

  initial begin
    lpagc_pkg::in_word_t w;
    logic [15:0] edge_vals[5];
    edge_vals = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0001, 16'hFFFF};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // manual mode at extreme gains with extreme samples
    cfg_write(lpagc_pkg::CFG_AGC_EN, 32'd0);
    foreach (edge_vals[k]) begin
      w.in_i = edge_vals[k];
      w.in_q = edge_vals[4 - k];
      send_word(w, 0);
    end
    drain();
    cfg_write(lpagc_pkg::CFG_MANUAL, 32'hFFFF_FFFF);
    foreach (edge_vals[k]) begin
      w.in_i = edge_vals[k];
      w.in_q = edge_vals[k];
      send_word(w, 1);
    end
    drain();
    cfg_write(lpagc_pkg::CFG_MANUAL, 32'd0);
    w.in_i = 16'h8000;
    w.in_q = 16'h7FFF;
    send_word(w, 0);
    drain();

    // agc, window 0 acts as one, full attack and zero max gain
    agc_setup(32768, 0, 0, 32'h7FFF_FFFF, 0, 0);
    foreach (edge_vals[k]) begin
      w.in_i = edge_vals[k];
      w.in_q = 16'h0000;
      send_word(w, 0);
    end
    drain();
    // window above depth, long hang, tiny target
    agc_setup(0, 32'hFFFF_FFFF, 32'd1073741824, 32'd1073741824, 8191, 65535);
    foreach (edge_vals[k]) begin
      w.in_i = 16'h0000;
      w.in_q = edge_vals[k];
      send_word(w, 0);
    end
    drain();
    // turning agc off loads the manual gain again
    cfg_write(lpagc_pkg::CFG_MANUAL, 32'h0002_0000);
    cfg_write(lpagc_pkg::CFG_AGC_EN, 32'd0);
    w.in_i = 16'h4000;
    w.in_q = 16'hC000;
    send_word(w, 0);
    drain();

    // random phases with random settings
    for (int unsigned ph = 0; ph < 10; ph++) begin
      if (ph == 3) begin
        cfg_write(lpagc_pkg::CFG_MANUAL, $urandom);
        cfg_write(lpagc_pkg::CFG_AGC_EN, 32'd0);
        fork
          random_words(150);
          begin
            repeat (200) @(posedge clk_i);
            hold_go = 1;
          end
        join
      end else begin
        agc_setup($urandom_range(0, 32768),
                  ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(65536, 1 << 24),
                  $urandom_range(0, 1 << 30),
                  $urandom_range(1 << 30, 32'h7FFF_FFFF),
                  (ph == 7) ? 4096 : ($urandom_range(0, 9) == 0 ? $urandom_range(0, 8191)
                                                                : $urandom_range(1, 48)),
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                              : $urandom_range(0, 20));
        if (ph == 5) begin
          fork
            random_words(150);
            begin
              repeat (300) @(posedge clk_i);
              hold_go = 1;
            end
          join
        end else begin
          random_words(150);
        end
      end
      drain();
    end

    repeat (200) @(posedge clk_i);
    $display("run covered manual and agc modes, extreme registers and samples,");
    $display("window changes and a long output hold-off; %0d words checked", sb.checked);
    if (sb.fails == 0 && sb.expected_q.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule

`default_nettype wire
